### src/imu6_pkg.sv
// Package for the six-axis IMU window averager: constants, beat types and divider request.
`default_nettype none

package imu6_pkg;

  localparam int WINDOW_DEPTH = 10;
  localparam int CAL_SAMPLES  = 100;

  localparam int AXES      = 6;
  localparam int GYRO_AXES = 3;
  localparam int AXIS_W    = $clog2(AXES);
  localparam int GAX_W     = $clog2(GYRO_AXES);

  localparam int SMP_W   = 16;
  localparam int SMP_MAX = 32767;
  localparam int SMP_MIN = -32768;

  localparam int SLOT_W    = $clog2(WINDOW_DEPTH);
  localparam int MEM_DEPTH = AXES * WINDOW_DEPTH;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);
  localparam int CNT_W     = (CAL_SAMPLES > 1) ? $clog2(CAL_SAMPLES) : 1;

  // Signed sums: a full window, and a full calibration run.
  localparam int WIN_SUM_W  = SMP_W + $clog2(WINDOW_DEPTH);
  localparam int BIAS_SUM_W = SMP_W + $clog2(CAL_SAMPLES);
  localparam int DIV_W      = (WIN_SUM_W > BIAS_SUM_W) ? WIN_SUM_W : BIAS_SUM_W;

  // Reciprocals are exact for any magnitude below 2**DIV_W since the shift
  // carries clog2(divisor) guard bits beyond the dividend width.
  localparam int RECIP_W   = DIV_W + 1;
  localparam int PROD_W    = DIV_W + RECIP_W;
  localparam int WIN_SHIFT = DIV_W + $clog2(WINDOW_DEPTH);
  localparam int CAL_SHIFT = DIV_W + $clog2(CAL_SAMPLES);
  localparam longint unsigned WIN_RECIP =
    ((64'd1 << WIN_SHIFT) + WINDOW_DEPTH - 1) / WINDOW_DEPTH;
  localparam longint unsigned CAL_RECIP =
    ((64'd1 << CAL_SHIFT) + CAL_SAMPLES - 1) / CAL_SAMPLES;

  localparam logic OP_FILTER = 1'b0;
  localparam logic OP_CAL    = 1'b1;

  localparam logic DIV_SEL_WIN = 1'b0;
  localparam logic DIV_SEL_CAL = 1'b1;

  typedef logic signed [SMP_W-1:0] smp_t;

  typedef struct packed {
    logic op;
    smp_t gyro_x_in;
    smp_t gyro_y_in;
    smp_t gyro_z_in;
    smp_t accel_x_in;
    smp_t accel_y_in;
    smp_t accel_z_in;
  } in_beat_t;

  typedef struct packed {
    smp_t gyro_x_out;
    smp_t gyro_y_out;
    smp_t gyro_z_out;
    smp_t accel_x_out;
    smp_t accel_y_out;
    smp_t accel_z_out;
  } out_beat_t;

  typedef struct packed {
    logic vld;
    logic sel;
  } div_req_t;

endpackage

`default_nettype wire

### src/imu_six_axis_window_average.sv
// Top level of the six-axis IMU window averager with gyro bias removal.
// A filter beat is accepted, then one accumulator walks the window memory one entry a
// cycle, then one divider serves all axes before out_valid rises.
// A new beat is taken only after the previous one finishes, and later while a result waits.
// A calibration beat adds its gyro samples to the bias sums; the last beat of a run also sets new biases.
// Reset is synchronous: control, row valid bits, biases and bias sums clear at once.
`default_nettype none

module imu_six_axis_window_average (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire imu6_pkg::in_beat_t    in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output imu6_pkg::out_beat_t        out_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SUM   = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_CAL   = 3'd4;
  localparam logic [2:0] S_BIAS  = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0]                                 state_r, state_nxt;
  logic [imu6_pkg::AXIS_W-1:0]                cnt_r, cnt_nxt;
  logic [imu6_pkg::AXIS_W-1:0]                rcnt_r, rcnt_nxt;
  logic [imu6_pkg::SLOT_W-1:0]                idx_r, idx_nxt;
  logic [imu6_pkg::MEM_AW-1:0]                addr_r, addr_nxt;
  logic [imu6_pkg::SLOT_W-1:0]                slot_r, slot_nxt;
  logic [imu6_pkg::WINDOW_DEPTH-1:0]          row_ok_r, row_ok_nxt;
  logic [imu6_pkg::CNT_W-1:0]                 cal_cnt_r, cal_cnt_nxt;
  logic [imu6_pkg::CNT_W:0]                   cal_total;

  imu6_pkg::smp_t                             smp_r [imu6_pkg::AXES];
  imu6_pkg::smp_t                             smp_nxt [imu6_pkg::AXES];
  imu6_pkg::smp_t                             res_r [imu6_pkg::AXES];
  imu6_pkg::smp_t                             res_nxt [imu6_pkg::AXES];
  logic signed [imu6_pkg::WIN_SUM_W-1:0]      sums_r [imu6_pkg::AXES];
  logic signed [imu6_pkg::WIN_SUM_W-1:0]      sums_nxt [imu6_pkg::AXES];
  imu6_pkg::smp_t                             bias_r [imu6_pkg::GYRO_AXES];
  imu6_pkg::smp_t                             bias_nxt [imu6_pkg::GYRO_AXES];
  logic signed [imu6_pkg::BIAS_SUM_W-1:0]     bsum_r [imu6_pkg::GYRO_AXES];
  logic signed [imu6_pkg::BIAS_SUM_W-1:0]     bsum_nxt [imu6_pkg::GYRO_AXES];
  logic signed [imu6_pkg::BIAS_SUM_W-1:0]     bsum_base;

  logic                                       p_vld_r, p_vld_nxt;
  logic                                       p_first_r, p_first_nxt;
  logic                                       p_last_r, p_last_nxt;
  logic                                       p_slot_r, p_slot_nxt;
  logic                                       p_row_ok_r, p_row_ok_nxt;
  logic [imu6_pkg::AXIS_W-1:0]                p_axis_r, p_axis_nxt;
  imu6_pkg::smp_t                             p_data_r, p_data_nxt;
  logic signed [imu6_pkg::WIN_SUM_W-1:0]      acc_r, acc_nxt;
  logic signed [imu6_pkg::WIN_SUM_W-1:0]      acc_sum;
  imu6_pkg::smp_t                             operand;

  logic                                       out_valid_r, out_valid_nxt;
  imu6_pkg::out_beat_t                        out_data_r, out_data_nxt;

  logic                                       ram_we;
  logic [imu6_pkg::SMP_W-1:0]                 ram_rd_data;
  imu6_pkg::div_req_t                         div_req;
  logic signed [imu6_pkg::DIV_W-1:0]          dividend;
  logic                                       quot_vld;
  logic signed [imu6_pkg::DIV_W-1:0]          quot;
  int                                         diff;

  imu6_ram #(
    .WIDTH (imu6_pkg::SMP_W),
    .DEPTH (imu6_pkg::MEM_DEPTH)
  ) u_window (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (addr_r),
    .wdata   (smp_r[cnt_r]),
    .raddr   (addr_r),
    .rd_data (ram_rd_data)
  );

  imu6_cdiv u_cdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (dividend),
    .quot_vld (quot_vld),
    .quot     (quot)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The new sample replaces its slot in the memory and feeds the sum directly.
  assign ram_we = (state_r == S_SUM) && (idx_r == slot_r);

  always_comb begin
    if (p_slot_r) begin
      operand = p_data_r;
    end else if (p_row_ok_r) begin
      operand = $signed(ram_rd_data);
    end else begin
      operand = '0;
    end
    acc_sum = (p_first_r ? imu6_pkg::WIN_SUM_W'(0) : acc_r)
            + imu6_pkg::WIN_SUM_W'(operand);
  end

  always_comb begin
    div_req.sel = (state_r == S_BIAS) ? imu6_pkg::DIV_SEL_CAL : imu6_pkg::DIV_SEL_WIN;
    div_req.vld = 1'b0;
    dividend    = '0;
    if (state_r == S_DIV && cnt_r < imu6_pkg::AXIS_W'(imu6_pkg::AXES)) begin
      div_req.vld = 1'b1;
      dividend    = imu6_pkg::DIV_W'(sums_r[cnt_r]);
    end else if (state_r == S_BIAS &&
                 cnt_r < imu6_pkg::AXIS_W'(imu6_pkg::GYRO_AXES)) begin
      div_req.vld = 1'b1;
      dividend    = imu6_pkg::DIV_W'(bsum_r[cnt_r[imu6_pkg::GAX_W-1:0]]);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rcnt_nxt      = rcnt_r;
    idx_nxt       = idx_r;
    addr_nxt      = addr_r;
    slot_nxt      = slot_r;
    row_ok_nxt    = row_ok_r;
    cal_cnt_nxt   = cal_cnt_r;
    cal_total     = {1'b0, cal_cnt_r} + (imu6_pkg::CNT_W + 1)'(1);
    smp_nxt       = smp_r;
    res_nxt       = res_r;
    sums_nxt      = sums_r;
    bias_nxt      = bias_r;
    bsum_nxt      = bsum_r;
    bsum_base     = '0;
    acc_nxt       = acc_r;
    diff          = 0;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r & out_stall;

    p_vld_nxt    = (state_r == S_SUM);
    p_first_nxt  = (idx_r == '0);
    p_last_nxt   = (idx_r == imu6_pkg::SLOT_W'(imu6_pkg::WINDOW_DEPTH - 1));
    p_slot_nxt   = (idx_r == slot_r);
    p_row_ok_nxt = row_ok_r[idx_r];
    p_axis_nxt   = cnt_r;
    p_data_nxt   = smp_r[cnt_r];

    if (p_vld_r) begin
      acc_nxt = acc_sum;
      if (p_last_r) begin
        sums_nxt[p_axis_r] = acc_sum;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          smp_nxt[0] = in_data.gyro_x_in;
          smp_nxt[1] = in_data.gyro_y_in;
          smp_nxt[2] = in_data.gyro_z_in;
          smp_nxt[3] = in_data.accel_x_in;
          smp_nxt[4] = in_data.accel_y_in;
          smp_nxt[5] = in_data.accel_z_in;
          cnt_nxt    = '0;
          idx_nxt    = '0;
          addr_nxt   = '0;
          state_nxt  = (in_data.op == imu6_pkg::OP_CAL) ? S_CAL : S_SUM;
        end
      end
      S_SUM: begin
        addr_nxt = addr_r + imu6_pkg::MEM_AW'(1);
        if (idx_r == imu6_pkg::SLOT_W'(imu6_pkg::WINDOW_DEPTH - 1)) begin
          idx_nxt = '0;
          cnt_nxt = cnt_r + imu6_pkg::AXIS_W'(1);
          if (cnt_r == imu6_pkg::AXIS_W'(imu6_pkg::AXES - 1)) begin
            state_nxt = S_DRAIN;
          end
        end else begin
          idx_nxt = idx_r + imu6_pkg::SLOT_W'(1);
        end
      end
      S_DRAIN: begin
        cnt_nxt   = '0;
        rcnt_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_req.vld) begin
          cnt_nxt = cnt_r + imu6_pkg::AXIS_W'(1);
        end
        if (quot_vld) begin
          rcnt_nxt = rcnt_r + imu6_pkg::AXIS_W'(1);
          if (rcnt_r < imu6_pkg::AXIS_W'(imu6_pkg::GYRO_AXES)) begin
            diff = int'(quot) - int'(bias_r[rcnt_r[imu6_pkg::GAX_W-1:0]]);
            if (diff > imu6_pkg::SMP_MAX) begin
              res_nxt[rcnt_r] = imu6_pkg::SMP_W'(imu6_pkg::SMP_MAX);
            end else if (diff < imu6_pkg::SMP_MIN) begin
              res_nxt[rcnt_r] = imu6_pkg::SMP_W'(imu6_pkg::SMP_MIN);
            end else begin
              res_nxt[rcnt_r] = imu6_pkg::SMP_W'(diff);
            end
          end else begin
            res_nxt[rcnt_r] = imu6_pkg::SMP_W'(quot);
          end
          if (rcnt_r == imu6_pkg::AXIS_W'(imu6_pkg::AXES - 1)) begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_CAL: begin
        // The first beat of a run starts the sums from zero.
        if (cal_cnt_r != '0) begin
          bsum_base = bsum_r[cnt_r[imu6_pkg::GAX_W-1:0]];
        end
        bsum_nxt[cnt_r[imu6_pkg::GAX_W-1:0]] =
          bsum_base + imu6_pkg::BIAS_SUM_W'(smp_r[cnt_r]);
        cnt_nxt = cnt_r + imu6_pkg::AXIS_W'(1);
        if (cnt_r == imu6_pkg::AXIS_W'(imu6_pkg::GYRO_AXES - 1)) begin
          if (cal_total == (imu6_pkg::CNT_W + 1)'(imu6_pkg::CAL_SAMPLES)) begin
            cal_cnt_nxt = '0;
            cnt_nxt     = '0;
            rcnt_nxt    = '0;
            state_nxt   = S_BIAS;
          end else begin
            cal_cnt_nxt = cal_total[imu6_pkg::CNT_W-1:0];
            state_nxt   = S_IDLE;
          end
        end
      end
      S_BIAS: begin
        if (div_req.vld) begin
          cnt_nxt = cnt_r + imu6_pkg::AXIS_W'(1);
        end
        if (quot_vld) begin
          rcnt_nxt = rcnt_r + imu6_pkg::AXIS_W'(1);
          bias_nxt[rcnt_r[imu6_pkg::GAX_W-1:0]] = imu6_pkg::SMP_W'(quot);
          if (rcnt_r == imu6_pkg::AXIS_W'(imu6_pkg::GYRO_AXES - 1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_data_nxt.gyro_x_out  = res_r[0];
          out_data_nxt.gyro_y_out  = res_r[1];
          out_data_nxt.gyro_z_out  = res_r[2];
          out_data_nxt.accel_x_out = res_r[3];
          out_data_nxt.accel_y_out = res_r[4];
          out_data_nxt.accel_z_out = res_r[5];
          out_valid_nxt            = 1'b1;
          row_ok_nxt[slot_r]       = 1'b1;
          if (slot_r == imu6_pkg::SLOT_W'(imu6_pkg::WINDOW_DEPTH - 1)) begin
            slot_nxt = '0;
          end else begin
            slot_nxt = slot_r + imu6_pkg::SLOT_W'(1);
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      rcnt_r      <= '0;
      idx_r       <= '0;
      addr_r      <= '0;
      slot_r      <= '0;
      row_ok_r    <= '0;
      cal_cnt_r   <= '0;
      p_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
      for (int a = 0; a < imu6_pkg::GYRO_AXES; a++) begin
        bias_r[a] <= '0;
        bsum_r[a] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rcnt_r      <= rcnt_nxt;
      idx_r       <= idx_nxt;
      addr_r      <= addr_nxt;
      slot_r      <= slot_nxt;
      row_ok_r    <= row_ok_nxt;
      cal_cnt_r   <= cal_cnt_nxt;
      p_vld_r     <= p_vld_nxt;
      out_valid_r <= out_valid_nxt;
      bias_r      <= bias_nxt;
      bsum_r      <= bsum_nxt;
    end
    smp_r      <= smp_nxt;
    res_r      <= res_nxt;
    sums_r     <= sums_nxt;
    acc_r      <= acc_nxt;
    p_first_r  <= p_first_nxt;
    p_last_r   <= p_last_nxt;
    p_slot_r   <= p_slot_nxt;
    p_row_ok_r <= p_row_ok_nxt;
    p_axis_r   <= p_axis_nxt;
    p_data_r   <= p_data_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTH
  a_acc_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    p_vld_r |-> (state_r == S_SUM || state_r == S_DRAIN))
    else $error("accumulator active outside the window walk");

  a_quot_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    quot_vld |-> (state_r == S_DIV || state_r == S_BIAS))
    else $error("divider result arrived with nobody collecting it");

  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_EMIT)
    else $error("result beat raised outside the emit state");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r < imu6_pkg::SLOT_W'(imu6_pkg::WINDOW_DEPTH))
    else $error("write slot beyond the window depth");

  a_cal_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, cal_cnt_r} < (imu6_pkg::CNT_W + 1)'(imu6_pkg::CAL_SAMPLES))
    else $error("calibration count past the run length");
`endif

endmodule

`default_nettype wire

### src/imu6_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module imu6_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rd_data_r <= mem_r[raddr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### src/imu6_cdiv.sv
// Two-stage signed divider by the window depth or the calibration count.
`default_nettype none

module imu6_cdiv (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire imu6_pkg::div_req_t                  req,
  input  wire logic signed [imu6_pkg::DIV_W-1:0]   dividend,
  output logic                                     quot_vld,
  output logic signed [imu6_pkg::DIV_W-1:0]        quot
);

  logic                                vld1_r;
  logic                                sel1_r;
  logic                                neg1_r;
  logic [imu6_pkg::PROD_W-1:0]         prod_r;
  logic [imu6_pkg::PROD_W-1:0]         prod_nxt;
  logic                                vld2_r;
  logic signed [imu6_pkg::DIV_W-1:0]   quot_r;
  logic signed [imu6_pkg::DIV_W-1:0]   quot_nxt;
  logic                                neg;
  logic [imu6_pkg::DIV_W-1:0]          mag;
  logic [imu6_pkg::RECIP_W-1:0]        recip;
  logic [imu6_pkg::DIV_W-1:0]          q;

  // Divide the magnitude so that the quotient truncates toward zero.
  always_comb begin
    neg   = dividend[imu6_pkg::DIV_W-1];
    mag   = neg ? imu6_pkg::DIV_W'(-dividend) : imu6_pkg::DIV_W'(dividend);
    recip = (req.sel == imu6_pkg::DIV_SEL_CAL) ? imu6_pkg::RECIP_W'(imu6_pkg::CAL_RECIP)
                                               : imu6_pkg::RECIP_W'(imu6_pkg::WIN_RECIP);
    prod_nxt = imu6_pkg::PROD_W'(mag) * imu6_pkg::PROD_W'(recip);
  end

  always_comb begin
    if (sel1_r == imu6_pkg::DIV_SEL_CAL) begin
      q = imu6_pkg::DIV_W'(prod_r >> imu6_pkg::CAL_SHIFT);
    end else begin
      q = imu6_pkg::DIV_W'(prod_r >> imu6_pkg::WIN_SHIFT);
    end
    quot_nxt = neg1_r ? -$signed(q) : $signed(q);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld1_r <= req.vld;
      vld2_r <= vld1_r;
    end
    sel1_r <= req.sel;
    neg1_r <= neg;
    prod_r <= prod_nxt;
    quot_r <= quot_nxt;
  end

  assign quot_vld = vld2_r;
  assign quot     = quot_r;

endmodule

`default_nettype wire

### test/imu_six_axis_window_average_test.sv
// Self-checking testbench for the six-axis IMU window averager with gyro bias removal.
module imu_six_axis_window_average_test;

  localparam int CLK_PERIOD   = 8;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int HOLD_CYCLES  = 600;
  localparam int PHASE_ITEMS  = 344;
  localparam int DRAIN_CYCLES = 120;

  localparam imu6_pkg::smp_t SMP_HI = imu6_pkg::smp_t'(imu6_pkg::SMP_MAX);
  localparam imu6_pkg::smp_t SMP_LO = imu6_pkg::smp_t'(imu6_pkg::SMP_MIN);

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  imu6_pkg::in_beat_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  imu6_pkg::out_beat_t out_data;

  imu6_pkg::in_beat_t  pending_beats [$];
  imu6_pkg::out_beat_t expected_avgs [$];
  int        tx_idle_pct = 0;
  int        rx_stall_pct = 0;
  logic      hold_on = 1'b0;
  int        hold_cycles = 0;
  logic      in_taken = 1'b0;
  int        mismatch_count = 0;
  int        cal_fill = 0;
  int        beats_queued = 0;
  string     field_name [imu6_pkg::AXES] = '{"gyro_x_out", "gyro_y_out", "gyro_z_out",
                                             "accel_x_out", "accel_y_out", "accel_z_out"};

  // Predicted block state.
  imu6_pkg::smp_t window_hist [imu6_pkg::AXES][imu6_pkg::WINDOW_DEPTH] = '{default: '0};
  int             next_slot = 0;
  imu6_pkg::smp_t gyro_bias [imu6_pkg::GYRO_AXES] = '{default: '0};
  int             bias_acc [imu6_pkg::GYRO_AXES] = '{default: 0};
  int             cal_seen = 0;

  imu_six_axis_window_average uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Updates the predicted state for one accepted beat; returns 1 when it yields a result.
  function automatic bit average_sample(input imu6_pkg::in_beat_t b,
                                        output imu6_pkg::out_beat_t r);
    imu6_pkg::smp_t raw [imu6_pkg::AXES];
    imu6_pkg::smp_t avg_out [imu6_pkg::AXES];
    int             acc;
    int             avg;
    raw = '{b.gyro_x_in, b.gyro_y_in, b.gyro_z_in, b.accel_x_in, b.accel_y_in, b.accel_z_in};
    r = '0;
    if (b.op == imu6_pkg::OP_CAL) begin
      if (cal_seen == 0) begin
        bias_acc = '{default: 0};
      end
      for (int a = 0; a < imu6_pkg::GYRO_AXES; a++) begin
        bias_acc[a] += int'(raw[a]);
      end
      cal_seen++;
      if (cal_seen >= imu6_pkg::CAL_SAMPLES) begin
        for (int a = 0; a < imu6_pkg::GYRO_AXES; a++) begin
          gyro_bias[a] = imu6_pkg::smp_t'(bias_acc[a] / imu6_pkg::CAL_SAMPLES);
        end
        cal_seen = 0;
      end
      return 1'b0;
    end
    for (int a = 0; a < imu6_pkg::AXES; a++) begin
      window_hist[a][next_slot] = raw[a];
    end
    next_slot = (next_slot + 1) % imu6_pkg::WINDOW_DEPTH;
    for (int a = 0; a < imu6_pkg::AXES; a++) begin
      acc = 0;
      for (int i = 0; i < imu6_pkg::WINDOW_DEPTH; i++) begin
        acc += int'(window_hist[a][i]);
      end
      avg = acc / imu6_pkg::WINDOW_DEPTH;
      if (a < imu6_pkg::GYRO_AXES) begin
        avg -= int'(gyro_bias[a]);
        if (avg > imu6_pkg::SMP_MAX) begin
          avg = imu6_pkg::SMP_MAX;
        end else if (avg < imu6_pkg::SMP_MIN) begin
          avg = imu6_pkg::SMP_MIN;
        end
      end
      avg_out[a] = imu6_pkg::smp_t'(avg);
    end
    r = '{avg_out[0], avg_out[1], avg_out[2], avg_out[3], avg_out[4], avg_out[5]};
    return 1'b1;
  endfunction

  function automatic imu6_pkg::smp_t rand_sample();
    case ($urandom_range(9))
      0: return SMP_HI;
      1: return SMP_LO;
      2: return imu6_pkg::smp_t'(int'($urandom_range(16)) - 8);
      default: return imu6_pkg::smp_t'($urandom());
    endcase
  endfunction

  task automatic queue_sample(input logic op,
                              input imu6_pkg::smp_t gx, input imu6_pkg::smp_t gy,
                              input imu6_pkg::smp_t gz, input imu6_pkg::smp_t ax,
                              input imu6_pkg::smp_t ay, input imu6_pkg::smp_t az);
    imu6_pkg::in_beat_t b;
    b = '{op, gx, gy, gz, ax, ay, az};
    pending_beats.push_back(b);
    beats_queued++;
    if (op == imu6_pkg::OP_CAL) begin
      cal_fill = (cal_fill + 1) % imu6_pkg::CAL_SAMPLES;
    end
  endtask

  // Queues calibration beats until the current run completes or max_len have gone.
  // Unpinned runs scatter noisy gyro values around the center and interleave filter beats.
  task automatic run_calibration(input imu6_pkg::smp_t center, input bit pinned,
                                 input int max_len);
    int             taken;
    imu6_pkg::smp_t g [imu6_pkg::GYRO_AXES];
    taken = 0;
    do begin
      if (!pinned && $urandom_range(6) == 0) begin
        queue_sample(imu6_pkg::OP_FILTER, rand_sample(), rand_sample(), rand_sample(),
                     rand_sample(), rand_sample(), rand_sample());
      end
      for (int a = 0; a < imu6_pkg::GYRO_AXES; a++) begin
        if (pinned) begin
          g[a] = center;
        end else if ($urandom_range(1) == 0) begin
          g[a] = imu6_pkg::smp_t'(int'(center) + int'($urandom_range(64)) - 32);
        end else begin
          g[a] = rand_sample();
        end
      end
      queue_sample(imu6_pkg::OP_CAL, g[0], g[1], g[2],
                   rand_sample(), rand_sample(), rand_sample());
      taken++;
    end while (cal_fill != 0 && taken < max_len);
  endtask

  task automatic queue_random(input int n);
    int             stop_at;
    int             burst;
    bit             steady;
    imu6_pkg::smp_t v [imu6_pkg::AXES];
    stop_at = beats_queued + n;
    while (beats_queued < stop_at) begin
      case ($urandom_range(19))
        0: begin
          if ($urandom_range(2) == 0) begin
            run_calibration(($urandom_range(1) == 0) ? SMP_HI : SMP_LO,
                            1'b1, imu6_pkg::CAL_SAMPLES);
          end else begin
            run_calibration(rand_sample(), 1'b0, imu6_pkg::CAL_SAMPLES);
          end
        end
        // A calibration run that is cut short and picked up again later.
        1: run_calibration(rand_sample(), 1'b0, $urandom_range(1, 40));
        default: begin
          burst = $urandom_range(1, 15);
          steady = ($urandom_range(3) == 0);
          for (int a = 0; a < imu6_pkg::AXES; a++) begin
            v[a] = rand_sample();
          end
          repeat (burst) begin
            if (!steady) begin
              for (int a = 0; a < imu6_pkg::AXES; a++) begin
                v[a] = rand_sample();
              end
            end
            queue_sample(imu6_pkg::OP_FILTER, v[0], v[1], v[2], v[3], v[4], v[5]);
          end
        end
      endcase
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_beats.size() != 0 || in_valid || expected_avgs.size() != 0);
    @(posedge clk);
  endtask

  // Driver: a new beat goes out once the previous one was taken at the last rising edge.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (pending_beats.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_data <= pending_beats.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= hold_on || (rx_stall_pct != 0 && $urandom_range(99) < rx_stall_pct);
  end

  always @(negedge clk) begin
    hold_cycles <= hold_on ? hold_cycles + 1 : 0;
  end

  // Monitor: checks result beats, then predicts from input beats taken at this edge.
  always @(posedge clk) begin
    imu6_pkg::out_beat_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_avgs.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("unexpected result beat %h", out_data);
          end
        end else begin
          want = expected_avgs.pop_front();
          for (int f = 0; f < imu6_pkg::AXES; f++) begin
            if (out_data[(imu6_pkg::AXES-1-f)*imu6_pkg::SMP_W +: imu6_pkg::SMP_W] !==
                want[(imu6_pkg::AXES-1-f)*imu6_pkg::SMP_W +: imu6_pkg::SMP_W]) begin
              mismatch_count++;
              if (mismatch_count <= 10) begin
                $display("mismatch on %s: expected %0d, got %0d", field_name[f],
                  $signed(want[(imu6_pkg::AXES-1-f)*imu6_pkg::SMP_W +: imu6_pkg::SMP_W]),
                  $signed(out_data[(imu6_pkg::AXES-1-f)*imu6_pkg::SMP_W +: imu6_pkg::SMP_W]));
              end
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (average_sample(in_data, want)) begin
          expected_avgs.push_back(want);
        end
      end
    end
    in_taken <= rst_n && in_valid && !in_stall;
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Extremes into a partly filled window, one calibration beat, then full windows.
    queue_sample(imu6_pkg::OP_FILTER, SMP_HI, SMP_HI, SMP_HI, SMP_HI, SMP_HI, SMP_HI);
    queue_sample(imu6_pkg::OP_FILTER, SMP_LO, SMP_LO, SMP_LO, SMP_LO, SMP_LO, SMP_LO);
    queue_sample(imu6_pkg::OP_FILTER, '0, '0, '0, '0, '0, '0);
    queue_sample(imu6_pkg::OP_FILTER, SMP_HI, SMP_LO, 16'sd1, -16'sd1, SMP_HI, SMP_LO);
    queue_sample(imu6_pkg::OP_CAL, SMP_LO, SMP_LO, SMP_LO, SMP_HI, SMP_LO, -16'sd1);
    repeat (imu6_pkg::WINDOW_DEPTH) queue_sample(imu6_pkg::OP_FILTER, SMP_HI, SMP_HI, SMP_HI,
                                                 SMP_HI, SMP_HI, SMP_HI);
    repeat (imu6_pkg::WINDOW_DEPTH) queue_sample(imu6_pkg::OP_FILTER, SMP_LO, SMP_LO, SMP_LO,
                                                 SMP_LO, SMP_LO, SMP_LO);
    wait_drained();

    // Extreme biases against full windows of the opposite extreme drive the gyro
    // outputs into saturation both ways.
    run_calibration(SMP_LO, 1'b1, imu6_pkg::CAL_SAMPLES);
    repeat (imu6_pkg::WINDOW_DEPTH) queue_sample(imu6_pkg::OP_FILTER, SMP_HI, SMP_HI, SMP_HI,
                                                 16'sd7, -16'sd7, '0);
    run_calibration(SMP_HI, 1'b1, imu6_pkg::CAL_SAMPLES);
    repeat (imu6_pkg::WINDOW_DEPTH) queue_sample(imu6_pkg::OP_FILTER, SMP_LO, SMP_LO, SMP_LO,
                                                 -16'sd3, 16'sd3, 16'sd1);
    wait_drained();

    // Receiver holds off while the sender keeps offering beats.
    hold_on = 1'b1;
    repeat (30) queue_sample(imu6_pkg::OP_FILTER, rand_sample(), rand_sample(), rand_sample(),
                             rand_sample(), rand_sample(), rand_sample());
    wait (hold_cycles >= HOLD_CYCLES);
    hold_on = 1'b0;
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 52; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 52; end
        default: begin tx_idle_pct = 14; rx_stall_pct = 14; end
      endcase
      queue_random(PHASE_ITEMS);
      wait_drained();
    end

    tx_idle_pct = 0;
    rx_stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_avgs.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("TB_ERROR");
    $finish;
  end

endmodule
